/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the shuffle RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/arsh_pkg.sv */
// ----------------------------------------------------------------------------
// arsh_pkg
// Types and fixed widths of the shuffle block.
// ----------------------------------------------------------------------------
package arsh_pkg;

   // Payload widths
   localparam int VALUE_W   = 32;
   localparam int RAND_W    = 31;
   localparam int BIT_CNT_W = $clog2(RAND_W);

   // Sequencer states
   typedef enum logic [3:0] {
      ST_LOAD,
      ST_RDRAND,
      ST_DIVGO,
      ST_DIVWAIT,
      ST_RDIJ,
      ST_WRI,
      ST_WRJ,
      ST_EMITRD,
      ST_EMITOUT
   } arsh_state_type;

   // Remainder unit status
   typedef struct packed {
      logic busy;
      logic done;
   } arsh_div_status_type;

endpackage

/* src/arsh_mod_unit.sv */
// ----------------------------------------------------------------------------
// arsh_mod_unit
// Bit-serial restoring remainder: dividend mod divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module arsh_mod_unit
   import arsh_pkg::*;
#(
   parameter int DIV_W = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [RAND_W-1:0]   dividend,
   input  logic [DIV_W-1:0]    divisor,
   output arsh_div_status_type status,
   output logic [DIV_W-1:0]    remainder
);

   logic [RAND_W-1:0]    shreg_ff, shreg_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     div_ff, div_in;
   logic [BIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_W:0]       trial;

   // Shift in the next dividend bit and subtract when it fits
   assign trial = {rem_ff, shreg_ff[RAND_W-1]};

   always_comb begin
      shreg_in = shreg_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = done_ff;
      if (start) begin
         shreg_in = dividend;
         rem_in   = '0;
         div_in   = divisor;
         cnt_in   = BIT_CNT_W'(RAND_W - 1);
         busy_in  = 1'b1;
         done_in  = 1'b0;
      end else if (busy_ff) begin
         shreg_in = {shreg_ff[RAND_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = DIV_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[DIV_W-1:0];
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      shreg_ff <= shreg_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      cnt_ff   <= cnt_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule

/* src/array_random_shuffle.sv */
// ----------------------------------------------------------------------------
// array_random_shuffle
// In-place Fisher-Yates shuffle of a loaded set, emitted as one run.
// ----------------------------------------------------------------------------
// Usage:
//   Load words on req_*: each carries an element and a random word; req_tlast
//   closes the set. Words past MAX_ELEMENTS are dropped and flag overflow.
//   After the closing word the block shuffles: for each index i from n-1
//   down to 1 it reads the next random word, takes it mod i+1 in a shared
//   bit-serial remainder unit and swaps elements i and j.
//   Each swap step is a random read, the remainder with its start, a
//   two-port element read and two single-port writes; rsp_tvalid rises
//   once the last swap step is done and element 0 has been read.
//   The run is then emitted on rsp_*, element 0 first; a word is read
//   only after the one before is taken. rsp_tlast marks the final word and
//   rsp_tuser carries the overflow flag on every word of the run.
//   req_tready is high only while loading. A stalled receiver holds the
//   current result word and the block waits; nothing is lost.
//   Reset returns to loading with an empty set; the stores need no clearing.
// ----------------------------------------------------------------------------
module array_random_shuffle
   import arsh_pkg::*;
#(
   parameter int MAX_ELEMENTS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [63:0]        req_tdata,   // [31:0] element_value, [62:32] random_word
   input  logic               req_tlast,   // last_element
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [VALUE_W-1:0] rsp_tdata,   // [31:0] shuffled_value
   output logic               rsp_tlast,   // run_end
   output logic               rsp_tuser    // [0] overflow
);

`include "assert_macros.svh"

   localparam int IDX_W = $clog2(MAX_ELEMENTS);
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_ELEMENTS);

   arsh_state_type state_ff, state_in;

   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             dropped_ff, dropped_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] draw_ff, draw_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] last_ff, last_in;

   logic [VALUE_W-1:0] elem_mem_ff [MAX_ELEMENTS];
   logic [RAND_W-1:0]  rand_mem_ff [MAX_ELEMENTS];
   logic [VALUE_W-1:0] rd_a_ff, rd_b_ff;
   logic [RAND_W-1:0]  rand_q_ff;

   logic req_fire, rsp_fire, store_ok;
   logic [CNT_W-1:0] n_next;
   logic [IDX_W-1:0] j_idx;

   logic               elem_we, rand_we;
   logic [IDX_W-1:0]   elem_waddr;
   logic [VALUE_W-1:0] elem_wdata;
   logic               rd_a_en, rd_b_en, rand_rd_en;
   logic [IDX_W-1:0]   rd_a_addr;
   logic               div_start;

   arsh_div_status_type div_status;
   logic [CNT_W-1:0]    div_rem;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign store_ok = (fill_ff != FULL_COUNT);
   assign n_next   = store_ok ? fill_ff + 1'b1 : fill_ff;
   assign j_idx    = div_rem[IDX_W-1:0];

   // Shared remainder unit
   arsh_mod_unit #(
      .DIV_W(CNT_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (rand_q_ff),
      .divisor   (CNT_W'(i_ff) + 1'b1),
      .status    (div_status),
      .remainder (div_rem)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_fire && req_tlast) begin
               state_in = (n_next == CNT_W'(1)) ? ST_EMITRD : ST_RDRAND;
            end
         end
         ST_RDRAND:  state_in = ST_DIVGO;
         ST_DIVGO:   state_in = ST_DIVWAIT;
         ST_DIVWAIT: begin
            if (div_status.done) begin
               state_in = ST_RDIJ;
            end
         end
         ST_RDIJ:    state_in = ST_WRI;
         ST_WRI:     state_in = ST_WRJ;
         ST_WRJ:     state_in = (i_ff == IDX_W'(1)) ? ST_EMITRD : ST_RDRAND;
         ST_EMITRD:  state_in = ST_EMITOUT;
         ST_EMITOUT: begin
            if (rsp_fire) begin
               state_in = (k_ff == last_ff) ? ST_LOAD : ST_EMITRD;
            end
         end
         default:    state_in = ST_LOAD;
      endcase
   end

   // Outputs and memory controls
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      div_start  = 1'b0;
      elem_we    = 1'b0;
      rand_we    = 1'b0;
      elem_waddr = fill_ff[IDX_W-1:0];
      elem_wdata = req_tdata[VALUE_W-1:0];
      rd_a_en    = 1'b0;
      rd_b_en    = 1'b0;
      rand_rd_en = 1'b0;
      rd_a_addr  = i_ff;
      case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            elem_we    = req_tvalid && store_ok;
            rand_we    = req_tvalid && store_ok;
         end
         ST_RDRAND: rand_rd_en = 1'b1;
         ST_DIVGO:  div_start  = 1'b1;
         ST_RDIJ: begin
            rd_a_en = 1'b1;
            rd_b_en = 1'b1;
         end
         ST_WRI: begin
            elem_we    = 1'b1;
            elem_waddr = i_ff;
            elem_wdata = rd_b_ff;
         end
         ST_WRJ: begin
            elem_we    = 1'b1;
            elem_waddr = j_idx;
            elem_wdata = rd_a_ff;
         end
         ST_EMITRD: begin
            rd_a_en   = 1'b1;
            rd_a_addr = k_ff;
         end
         ST_EMITOUT: rsp_tvalid = 1'b1;
         default: begin
         end
      endcase
   end

   // Counters and flags
   always_comb begin
      fill_in    = fill_ff;
      dropped_in = dropped_ff;
      i_in       = i_ff;
      draw_in    = draw_ff;
      k_in       = k_ff;
      last_in    = last_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               fill_in = n_next;
               if (!store_ok) begin
                  dropped_in = 1'b1;
               end
               if (req_tlast) begin
                  last_in = IDX_W'(n_next - 1'b1);
                  i_in    = IDX_W'(n_next - 1'b1);
                  draw_in = '0;
                  k_in    = '0;
               end
            end
         end
         ST_WRJ: begin
            i_in    = i_ff - 1'b1;
            draw_in = draw_ff + 1'b1;
         end
         ST_EMITOUT: begin
            if (rsp_fire) begin
               k_in = k_ff + 1'b1;
               if (k_ff == last_ff) begin
                  fill_in    = '0;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         fill_ff    <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         dropped_ff <= dropped_in;
      end
   end

   // Indexes
   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      draw_ff <= draw_in;
      k_ff    <= k_in;
      last_ff <= last_in;
   end

   // Element store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (elem_we) begin
         elem_mem_ff[elem_waddr] <= elem_wdata;
      end
      if (rd_a_en) begin
         rd_a_ff <= elem_mem_ff[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_ff <= elem_mem_ff[j_idx];
      end
   end

   // Random word store
   always_ff @(posedge clock) begin
      if (rand_we) begin
         rand_mem_ff[fill_ff[IDX_W-1:0]] <= req_tdata[VALUE_W+RAND_W-1:VALUE_W];
      end
      if (rand_rd_en) begin
         rand_q_ff <= rand_mem_ff[draw_ff];
      end
   end

   assign rsp_tdata = rd_a_ff;
   assign rsp_tlast = (k_ff == last_ff);
   assign rsp_tuser = dropped_ff;

   // Checks
   `ASSERT_SAME(a_no_load_during_emit, clock, reset, rsp_tvalid, !req_tready,
      "result offered while loading")
   `ASSERT_NEXT(a_close_stops_load, clock, reset, req_fire && req_tlast, !req_tready,
      "still loading after set was closed")
   `ASSERT_NEXT(a_run_end_reloads, clock, reset, rsp_fire && rsp_tlast, req_tready,
      "not loading after run end")
   `ASSERT_SAME(a_div_idle_on_start, clock, reset, div_start, !div_status.busy,
      "remainder unit restarted while busy")

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the in-place shuffle block. Random sets of signed elements,
// each word carrying its own random draw, are loaded on the request stream.
// A scoreboard replays the shuffle on every closed set and compares each
// emitted word field by field. It covers single-element sets, a set that
// overflows the store, and runs through phases of sender idling and
// receiver back-pressure.
// ----------------------------------------------------------------------------
module tb
   import arsh_pkg::*;
();

   localparam int DEPTH       = 64;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 60;

   // Replays the Durstenfeld shuffle and holds the words still owed
   class shuffle_scoreboard;
      typedef struct packed {
         logic [VALUE_W-1:0] value;
         logic               run_end;
         logic               overflow;
      } shuffled_word_type;

      int                 max_elements;
      logic [VALUE_W-1:0] set_values[$];
      logic [RAND_W-1:0]  set_draws[$];
      bit                 dropped;
      shuffled_word_type  expected_run[$];
      int                 errors;

      function new(int depth);
         max_elements = depth;
         dropped      = 1'b0;
         errors       = 0;
      endfunction

      task report(string what);
         $display("MISMATCH at %0t: %s", $time, what);
         errors++;
      endtask

      // Store one accepted word; on the closing word shuffle and queue the run
      function void note_input(logic [63:0] data, logic last);
         int                 i;
         int unsigned        j;
         int unsigned        draw_word;
         int                 draw;
         logic [VALUE_W-1:0] held;
         shuffled_word_type  w;
         if (set_values.size() < max_elements) begin
            set_values.push_back(data[31:0]);
            set_draws.push_back(data[62:32]);
         end else begin
            dropped = 1'b1;
         end
         if (!last) return;
         draw = 0;
         for (i = set_values.size() - 1; i > 0; i--) begin
            draw_word     = set_draws[draw];
            j             = draw_word % (i + 1);
            held          = set_values[i];
            set_values[i] = set_values[j];
            set_values[j] = held;
            draw++;
         end
         foreach (set_values[k]) begin
            w.value    = set_values[k];
            w.run_end  = (k == set_values.size() - 1);
            w.overflow = dropped;
            expected_run.push_back(w);
         end
         set_values.delete();
         set_draws.delete();
         dropped = 1'b0;
      endfunction

      // Compare one emitted word with the oldest owed word
      task check_result(logic [VALUE_W-1:0] value, logic last, logic user);
         shuffled_word_type want;
         if (expected_run.size() == 0) begin
            report($sformatf("unexpected word value=%h last=%b ovf=%b", value, last, user));
            return;
         end
         want = expected_run.pop_front();
         if (value !== want.value)
            report($sformatf("value %h, want %h", value, want.value));
         if (last !== want.run_end)
            report($sformatf("run end %b, want %b", last, want.run_end));
         if (user !== want.overflow)
            report($sformatf("overflow %b, want %b", user, want.overflow));
      endtask

      task check_leftovers();
         if (expected_run.size() != 0)
            report($sformatf("%0d words never emitted", expected_run.size()));
      endtask
   endclass

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [63:0]        req_tdata  = '0;  // [31:0] element_value, [62:32] random_word
   logic               req_tlast  = 1'b0;  // last_element
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [VALUE_W-1:0] rsp_tdata;  // [31:0] shuffled_value
   logic               rsp_tlast;  // run_end
   logic               rsp_tuser;  // [0] overflow

   int tx_idle_pct  = 0;
   int rx_stall_pct = 0;
   int cycle_count  = 0;

   shuffle_scoreboard shuffler = new(DEPTH);

   array_random_shuffle #(
      .MAX_ELEMENTS(DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Throttle the result side at the phase's stall rate
   always @(posedge clock) begin
      if (rx_stall_pct == 0)
         rsp_tready <= 1'b1;
      else
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
   end

   // Watch both handshakes, and bail out on a hang
   always @(posedge clock) begin
      cycle_count++;
      if (!reset) begin
         if (req_tvalid && req_tready)
            shuffler.note_input(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready)
            shuffler.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Offer one word, idling first at the phase's rate, and hold until taken
   task send_word(input logic [VALUE_W-1:0] value, input logic [RAND_W-1:0] draw,
                  input logic last);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, draw, value};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   // Load a set of random content, closing it on the final word
   task send_random_set(input int count);
      logic [VALUE_W-1:0] value;
      logic [RAND_W-1:0]  draw;
      int                 pick;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         if (pick < 5)       value = 32'h8000_0000;
         else if (pick < 10) value = 32'h7FFF_FFFF;
         else if (pick < 15) value = 32'hFFFF_FFFF;
         else if (pick < 20) value = 32'h0000_0000;
         else                value = $urandom;
         pick = $urandom_range(99);
         if (pick < 10)      draw = '0;
         else if (pick < 20) draw = '1;
         else if (pick < 50) draw = RAND_W'($urandom_range(200));
         else                draw = RAND_W'($urandom);
         send_word(value, draw, k == count - 1);
      end
   endtask

   // Park the sender until every owed word has been emitted
   task wait_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (shuffler.expected_run.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      int phase_items;
      int set_size;
      int pick;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: single element, two-element swap and no-swap, field extremes
      send_word(32'h8000_0000, 31'h7FFF_FFFF, 1'b1);
      send_word(32'h7FFF_FFFF, 31'h0000_0000, 1'b0);
      send_word(32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1);
      send_word(32'h0000_0000, 31'h0000_0001, 1'b0);
      send_word(32'h8000_0000, 31'h0000_0000, 1'b1);
      // Draws that pick the element itself, a wrapped maximum, a pattern
      send_word(32'h0000_0001, 31'h0000_0003, 1'b0);
      send_word(32'h0000_0002, 31'h7FFF_FFFF, 1'b0);
      send_word(32'h0000_0003, 31'h5555_5555, 1'b0);
      send_word(32'h0000_0004, 31'h2AAA_AAAA, 1'b1);
      send_word(32'hAAAA_AAAA, 31'h7FFF_FFFF, 1'b0);
      send_word(32'h5555_5555, 31'h0000_0000, 1'b0);
      send_word(32'h8000_0000, 31'h7FFF_FFFE, 1'b0);
      send_word(32'h7FFF_FFFF, 31'h0000_0006, 1'b0);
      send_word(32'hFFFF_FFFF, 31'h4000_0000, 1'b0);
      send_word(32'h0000_0000, 31'h0000_0002, 1'b0);
      send_word(32'h1234_5678, 31'h3FFF_FFFF, 1'b0);
      send_word(32'hFEDC_BA98, 31'h7FFF_FFFF, 1'b1);
      wait_drain();

      // Random phases: free running, idle sender, stalled receiver, both
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 77; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 77; end
            default: begin tx_idle_pct = 33; rx_stall_pct = 33; end
         endcase
         phase_items = 0;
         while (phase_items < 14) begin
            pick = $urandom_range(99);
            if (pick < 15)      set_size = 1;
            else if (pick < 85) set_size = $urandom_range(6, 2);
            else                set_size = $urandom_range(10, 7);
            send_random_set(set_size);
            phase_items += set_size;
         end
         // Overflow: a dropped word before the close and a dropped closing word
         if (phase == 2)
            send_random_set(DEPTH + 2);
         wait_drain();
      end

      repeat (SETTLE) @(posedge clock);
      shuffler.check_leftovers();
      if (shuffler.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
